// File: hdl/skf_pkg.sv
// Shared types and constants of the scalar Kalman filter.
package skf_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 1'd1;

  // Sequencer states of one filter step.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DEN,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL_GO,
    S_MUL_WAIT,
    S_DONE
  } state_t;

endpackage

// File: hdl/skf_div.sv
// Restoring divider that yields the gain one quotient bit per cycle.
module skf_div #(
  parameter int DW = 32,
  parameter int GF = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW:0]   den,
  output logic          done,
  output logic [GF:0]   quo
);

  localparam int CW = $clog2(GF + 2);

  logic [DW+1:0] rem_r;
  logic [DW:0]   den_r;
  logic [GF:0]   quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic          ge;
  logic [DW+1:0] diff;
  logic [DW+1:0] kept;

  always_comb begin
    ge   = rem_r >= {1'b0, den_r};
    diff = rem_r - {1'b0, den_r};
    kept = ge ? diff : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(GF + 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {2'b00, num};
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so the doubled value fits.
      rem_r <= {kept[DW:0], 1'b0};
      quo_r <= {quo_r[GF-1:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: hdl/skf_mul.sv
// Shift-add multiplier that scales by a gain fraction and rounds half up.
module skf_mul #(
  parameter int AW = 32,
  parameter int GF = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [GF:0]   b,
  output logic          done,
  output logic [AW-1:0] prod
);

  localparam int CW = $clog2(GF + 2);

  logic [AW-1:0] a_r;
  logic [AW-1:0] hi_r;
  logic [GF:0]   lo_r;
  logic [AW-1:0] prod_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          rnd_r;
  logic          done_r;

  logic [AW:0]   sum;
  logic [AW:0]   rounded;

  always_comb begin
    sum     = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
    // Product shifted down by GF, plus the bit just below the cut.
    rounded = {hi_r, lo_r[GF]} + (AW + 1)'(lo_r[GF-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      rnd_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(GF + 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          rnd_r  <= 1'b1;
        end
      end else if (rnd_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= sum[AW:1];
      lo_r <= {sum[0], lo_r[GF:1]};
    end
    if (rnd_r) begin
      prod_r <= rounded[AW-1:0];
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// File: hdl/scalar_kalman_filter.sv
// Top level of the one-dimensional fixed-point Kalman filter.
//
//   port group  | dir | handshake               | payload
//   in_         | in  | in_valid / in_ready     | in_sample (signed)
//   out_        | out | out_valid / out_ready   | out_estimate (signed)
//   cfg_        | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Each item passes through the bit-serial gain divider followed by the bit-serial
// multipliers.
// Items are handled one at a time; the next item is taken while a result waits.
// A result that cannot leave holds the step in its last state until out_ready.
// Synchronous active-low reset clears the estimate, covariance and both noise terms.
module scalar_kalman_filter #(
  parameter int DATA_WIDTH     = 32,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DATA_WIDTH-1:0]  in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]  out_estimate,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]         cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int GF = GAIN_FRAC_BITS;
  localparam logic [GF:0] GAIN_ONE = {1'b1, {GF{1'b0}}};

  skf_pkg::state_t state_r, state_nxt;

  logic [DW-1:0] q_r;
  logic [DW-1:0] r_r;
  logic [DW-1:0] est_r;
  logic [DW-1:0] cov_r;
  logic [DW-1:0] smp_r;
  logic [DW-1:0] pm_r;
  logic [DW:0]   mag_r;
  logic          neg_r;
  logic [DW:0]   den_r;
  logic [GF:0]   k_r;
  logic          out_valid_r;
  logic [DW-1:0] out_estimate_r;

  logic          div_start;
  logic          div_done;
  logic [GF:0]   div_quo;
  logic          mul_start;
  logic          est_mul_done;
  logic          cov_mul_done;
  logic [DW:0]   inc;
  logic [DW-1:0] cov_new;
  logic          finish;

  logic [DW:0]   pm_sum;
  logic [DW-1:0] pm_sat;
  logic [DW:0]   diff;
  logic [DW:0]   est_ext;
  logic [DW:0]   est_new;
  logic [GF:0]   k_comp;

  // Datapath helpers.
  always_comb begin
    pm_sum  = {1'b0, cov_r} + {1'b0, q_r};
    pm_sat  = pm_sum[DW] ? '1 : pm_sum[DW-1:0];
    diff    = {smp_r[DW-1], smp_r} - {est_r[DW-1], est_r};
    est_ext = {est_r[DW-1], est_r};
    // The new estimate lies between the old one and the sample, so it fits.
    est_new = neg_r ? (est_ext - inc) : (est_ext + inc);
    k_comp  = GAIN_ONE - k_r;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skf_pkg::S_IDLE:     if (in_valid) state_nxt = skf_pkg::S_PREP;
      skf_pkg::S_PREP:     state_nxt = skf_pkg::S_DEN;
      skf_pkg::S_DEN:      state_nxt = skf_pkg::S_DIV_GO;
      skf_pkg::S_DIV_GO:   state_nxt = skf_pkg::S_DIV_WAIT;
      skf_pkg::S_DIV_WAIT: if (div_done) state_nxt = skf_pkg::S_MUL_GO;
      skf_pkg::S_MUL_GO:   state_nxt = skf_pkg::S_MUL_WAIT;
      skf_pkg::S_MUL_WAIT: if (est_mul_done) state_nxt = skf_pkg::S_DONE;
      skf_pkg::S_DONE:     if (!out_valid_r || out_ready) state_nxt = skf_pkg::S_IDLE;
      default:             state_nxt = skf_pkg::S_IDLE;
    endcase
  end

  // State-decoded controls.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    finish    = 1'b0;
    case (state_r)
      skf_pkg::S_IDLE:   in_ready  = 1'b1;
      skf_pkg::S_DIV_GO: div_start = 1'b1;
      skf_pkg::S_MUL_GO: mul_start = 1'b1;
      skf_pkg::S_DONE:   finish    = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skf_pkg::S_IDLE;
      q_r         <= '0;
      r_r         <= '0;
      est_r       <= '0;
      cov_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          skf_pkg::CFG_PROCESS_NOISE: q_r <= cfg_data;
          skf_pkg::CFG_MEASURE_NOISE: r_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (finish) begin
        est_r       <= est_new[DW-1:0];
        cov_r       <= cov_new;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r <= in_sample;
    end
    if (state_r == skf_pkg::S_PREP) begin
      pm_r  <= pm_sat;
      neg_r <= diff[DW];
      mag_r <= diff[DW] ? -diff : diff;
    end
    if (state_r == skf_pkg::S_DEN) begin
      den_r <= {1'b0, pm_r} + {1'b0, r_r};
    end
    if (div_done) begin
      // A zero denominator gives a zero gain.
      k_r <= (den_r == '0) ? '0 : div_quo;
    end
    if (finish) begin
      out_estimate_r <= est_new[DW-1:0];
    end
  end

  skf_div #(
    .DW(DW),
    .GF(GF)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (pm_r),
    .den  (den_r),
    .done (div_done),
    .quo  (div_quo)
  );

  skf_mul #(
    .AW(DW + 1),
    .GF(GF)
  ) u_est_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mag_r),
    .b    (k_r),
    .done (est_mul_done),
    .prod (inc)
  );

  skf_mul #(
    .AW(DW),
    .GF(GF)
  ) u_cov_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (pm_r),
    .b    (k_comp),
    .done (cov_mul_done),
    .prod (cov_new)
  );

  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_estimate = out_estimate_r;

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == skf_pkg::S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_muls_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    est_mul_done == cov_mul_done)
    else $error("multipliers finished on different cycles");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == skf_pkg::S_MUL_GO |-> k_r <= GAIN_ONE)
    else $error("gain above one");

  a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == skf_pkg::S_DONE |-> cov_new <= pm_r)
    else $error("updated covariance above predicted covariance");
`endif

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the fixed-point scalar Kalman filter.
module tb_top;

  localparam int     DW          = 32;
  localparam longint GAIN_ONE    = 65536;
  localparam longint GAIN_HALF   = 32768;
  localparam longint DATA_MAX    = 64'hFFFF_FFFF;
  localparam int     QUIET_LIMIT = 3000;
  localparam int     LONG_HOLD   = 400;
  localparam int     PHASES      = 6;
  localparam int     PHASE_ITEMS = 115;
  localparam int     SETTLE      = 50;

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic signed [DW-1:0]          in_sample    = '0;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic signed [DW-1:0]          out_estimate;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index    = skf_pkg::CFG_PROCESS_NOISE;
  logic [DW-1:0]                 cfg_data     = '0;

  scalar_kalman_filter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_estimate (out_estimate),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Samples waiting to be offered, and estimates waiting to come back.
  logic signed [DW-1:0] sample_q[$];
  logic signed [DW-1:0] estimate_q[$];

  // Filter state and noise terms as the block should hold them.
  logic [DW-1:0]        q_noise   = '0;
  logic [DW-1:0]        r_noise   = '0;
  logic [DW-1:0]        cov_track = '0;
  logic signed [DW-1:0] est_track = '0;

  int samples_queued = 0;
  int samples_taken  = 0;
  int estimates_seen = 0;
  int mismatch_count = 0;
  int settings_used  = 0;
  int quiet          = 0;
  int hold_left      = 0;
  int drift          = 0;
  bit hold_done      = 1'b0;
  bit in_fired       = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  // One filter update: advances the tracked state and returns the new estimate.
  function automatic logic signed [DW-1:0] filter_step(logic signed [DW-1:0] smp);
    longint est, diff, mag, inc, pm, den, gain, cov;
    est = est_track;
    pm = cov_track;
    pm = pm + q_noise;
    if (pm > DATA_MAX) pm = DATA_MAX;
    den = pm + r_noise;
    gain = (den == 0) ? 0 : (pm << 16) / den;
    diff = longint'(smp) - est;
    mag = (diff < 0) ? -diff : diff;
    // Rounding on the magnitude gives half away from zero on the signed step.
    inc = (mag * gain + GAIN_HALF) >>> 16;
    est = (diff < 0) ? est - inc : est + inc;
    cov = (pm * (GAIN_ONE - gain) + GAIN_HALF) >>> 16;
    cov_track = cov[DW-1:0];
    est_track = est[DW-1:0];
    return est[DW-1:0];
  endfunction

  function automatic bit no_gaps();
    return samples_taken >= 300 && samples_taken < 420;
  endfunction

  task automatic note_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    logic signed [DW-1:0] want;
    in_fired <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      estimates_seen++;
      if (estimate_q.size() == 0) begin
        note_mismatch($sformatf("estimate %h arrived with none expected", out_estimate));
      end else begin
        want = estimate_q.pop_front();
        if (out_estimate !== want)
          note_mismatch($sformatf("estimate %0d: got %h, expected %h",
                                  estimates_seen, out_estimate, want));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      estimate_q.push_back(filter_step(in_sample));
      samples_taken++;
    end
  end

  always @(negedge clk) begin : sample_drive
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (sample_q.size() != 0 && (no_gaps() || $urandom_range(99) >= 35)) begin
        in_valid  <= 1'b1;
        in_sample <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The long hold lets the block take one more item and then stall its input.
  always @(negedge clk) begin : ready_drive
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && estimates_seen >= 150) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_gaps() || $urandom_range(99) >= 35;
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d estimates outstanding",
               quiet, estimate_q.size());
      $display("[scalar_kalman_filter] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_noise(logic [skf_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == skf_pkg::CFG_PROCESS_NOISE) q_noise = value;
    else r_noise = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_noise(logic [DW-1:0] q, logic [DW-1:0] r);
    write_noise(skf_pkg::CFG_PROCESS_NOISE, q);
    write_noise(skf_pkg::CFG_MEASURE_NOISE, r);
    settings_used++;
  endtask

  task automatic queue_sample(logic signed [DW-1:0] smp);
    sample_q.push_back(smp);
    samples_queued++;
  endtask

  // Waits until every queued item has been filtered and its estimate checked.
  task automatic drain();
    while (samples_taken < samples_queued || estimate_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [DW-1:0] pick_noise();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    if (roll < 60) return $urandom_range(32'h0004_0000);
    return $urandom;
  endfunction

  // Mostly a slowly wandering signal with measurement noise, plus wild values.
  function automatic logic signed [DW-1:0] pick_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) drift = $urandom;
    if (roll < 50) begin
      drift = drift + int'($urandom_range(8192)) - 4096;
      return drift + int'($urandom_range(2048)) - 1024;
    end
    if (roll < 78) return $urandom;
    if (roll < 88) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return int'($urandom_range(32'h0002_0000)) - 32'h0001_0000;
  endfunction

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Both noise terms still zero after reset: zero denominator, estimate holds.
    settings_used++;
    queue_sample(32'h7FFF_FFFF);
    queue_sample(32'h8000_0000);
    queue_sample(32'h0001_0000);
    drain();

    // No measurement noise: the gain is one and the estimate follows the sample.
    set_noise(32'h0001_0000, 32'h0000_0000);
    queue_sample(32'h7FFF_FFFF);
    queue_sample(32'h8000_0000);
    queue_sample(32'h0000_0000);
    queue_sample(32'hFFFF_FFFF);
    queue_sample(32'h0000_0001);
    queue_sample(32'h8000_0000);
    drain();

    // Largest noise terms: the predicted covariance saturates.
    set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_sample(32'h7FFF_FFFF);
    queue_sample(32'h7FFF_FFFF);
    queue_sample(32'h8000_0000);
    queue_sample(32'h0000_0000);
    queue_sample(32'hFFFF_FFFF);
    drain();

    // No process noise against a huge measurement noise: the gain shrinks away.
    set_noise(32'h0000_0000, 32'hFFFF_FFFF);
    queue_sample(32'h8000_0000);
    queue_sample(32'h7FFF_FFFF);
    queue_sample(32'hFFFF_FFFF);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_noise(pick_noise(), pick_noise());
      for (int i = 0; i < PHASE_ITEMS; i++) queue_sample(pick_sample());
      drain();
    end

    $display("Filtered %0d samples and checked %0d estimates under %0d noise settings,",
             samples_taken, estimates_seen, settings_used);
    $display("including a %0d-cycle output stall that backed up the input.", LONG_HOLD);
    if (mismatch_count == 0) begin
      $display("[scalar_kalman_filter] OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[scalar_kalman_filter] ERROR");
    end
    $finish;
  end

endmodule
